/* rtl/core/ptpso_pkg.sv */
// Package for the PTPv1 slave sync/offset block.
// Holds the transaction payload types, status and mode codes, and time constants.
// Depends on nothing.
package ptpso_pkg;

    localparam logic [15:0] PTP_VERSION_1   = 16'h0001;
    localparam logic [7:0]  MSG_TYPE_EVENT   = 8'h01;
    localparam logic [7:0]  MSG_TYPE_GENERAL = 8'h02;
    localparam logic [7:0]  CTRL_SYNC        = 8'h00;
    localparam logic [7:0]  CTRL_FOLLOW_UP   = 8'h02;
    localparam logic [7:0]  CTRL_DELAY_RESP  = 8'h03;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_NOT_V1      = 3'd1;
    localparam logic [2:0] STATUS_UNSUPPORTED = 3'd2;
    localparam logic [2:0] STATUS_SYNC_BUSY   = 3'd3;
    localparam logic [2:0] STATUS_FUP_MISMATCH = 3'd4;

    localparam logic [1:0] MODE_IDLE        = 2'd0;
    localparam logic [1:0] MODE_AWAIT_FUP   = 2'd1;
    localparam logic [1:0] MODE_AWAIT_DRESP = 2'd3;

    localparam logic [32:0] NSEC_PER_SEC = 33'd1000000000;

    typedef struct packed {
        logic [15:0] version_word;
        logic [7:0]  message_type;
        logic [7:0]  control_code;
        logic [47:0] source_uuid;
        logic [15:0] sequence_number;
        logic [31:0] stamp_sec;
        logic [29:0] stamp_nsec;
        logic [31:0] local_sec;
        logic [29:0] local_nsec;
        logic [31:0] request_sent_sec;
        logic [29:0] request_sent_nsec;
    } msg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  mode_after;
        logic        send_delay_request;
        logic        clock_set;
        logic [31:0] corrected_sec;
        logic [29:0] corrected_nsec;
    } res_t;

endpackage

/* rtl/core/ptpso_msg_if.sv */
// Valid/ready channel carrying one PTPv1 message transaction.
// Depends on ptpso_pkg for msg_t.
interface ptpso_msg_if import ptpso_pkg::*; ();
    logic valid;
    logic ready;
    msg_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ptpso_res_if.sv */
// Valid/ready channel carrying one result transaction.
// Depends on ptpso_pkg for res_t.
interface ptpso_res_if import ptpso_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ptp_slave_sync_offset.sv */
// PTPv1 slave sync/offset engine: decode, state update and corrected time.
// A message transaction is registered in the input stage, its result in the result register.
// Throughput: 1 message per cycle while result.ready holds; the state update and the
// offset arithmetic sit between the input register and the result register.
// Reset: rst_n asynchronous active low; mode idle, held id, sequence and
// differences cleared, both stages empty.
module ptp_slave_sync_offset import ptpso_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ptpso_msg_if.sink    msg,
    ptpso_res_if.source  result
);

    localparam logic [2:0] KIND_BAD_VERSION = 3'd0;
    localparam logic [2:0] KIND_SYNC        = 3'd1;
    localparam logic [2:0] KIND_FOLLOW_UP   = 3'd2;
    localparam logic [2:0] KIND_DELAY_RESP  = 3'd3;
    localparam logic [2:0] KIND_UNSUPPORTED = 3'd4;

    // input stage
    logic               s1_valid_reg;
    logic [2:0]         s1_kind_reg;
    logic [47:0]        s1_uuid_reg;
    logic [15:0]        s1_seq_reg;
    logic [31:0]        s1_local_sec_reg;
    logic [29:0]        s1_local_nsec_reg;
    logic signed [32:0] s1_fwd_sec_reg;
    logic signed [30:0] s1_fwd_nsec_reg;
    logic signed [32:0] s1_back_sec_reg;
    logic signed [30:0] s1_back_nsec_reg;

    // state
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [47:0]        held_uuid_reg;
    logic [47:0]        held_uuid_next;
    logic [15:0]        held_seq_reg;
    logic [15:0]        held_seq_next;
    logic signed [32:0] fwd_sec_reg;
    logic signed [32:0] fwd_sec_next;
    logic signed [30:0] fwd_nsec_reg;
    logic signed [30:0] fwd_nsec_next;

    // result stage
    logic               out_valid_reg;
    res_t               out_data_reg;
    res_t               out_data_next;

    logic               out_free;
    logic               s1_advance;
    logic               msg_accept;
    logic [2:0]         in_kind;

    logic signed [33:0] diff_sec;
    logic signed [33:0] diff_sec_adj;
    logic signed [32:0] half_sec;
    logic signed [31:0] diff_nsec;
    logic signed [31:0] diff_nsec_adj;
    logic signed [30:0] half_nsec;
    logic signed [32:0] raw_nsec;
    logic [32:0]        norm_nsec;
    logic [31:0]        base_sec;
    logic [31:0]        norm_sec;
    logic [16:0]        seq_expected;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign msg.ready  = !s1_valid_reg || out_free;
    assign msg_accept = msg.valid && msg.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        if (msg.data.version_word != PTP_VERSION_1)
        begin
            in_kind = KIND_BAD_VERSION;
        end
        else if (msg.data.control_code == CTRL_SYNC && msg.data.message_type == MSG_TYPE_EVENT)
        begin
            in_kind = KIND_SYNC;
        end
        else if (msg.data.control_code == CTRL_FOLLOW_UP
                 && msg.data.message_type == MSG_TYPE_GENERAL)
        begin
            in_kind = KIND_FOLLOW_UP;
        end
        else if (msg.data.control_code == CTRL_DELAY_RESP
                 && msg.data.message_type == MSG_TYPE_GENERAL)
        begin
            in_kind = KIND_DELAY_RESP;
        end
        else
        begin
            in_kind = KIND_UNSUPPORTED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            s1_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_accept)
        begin
            s1_kind_reg       <= in_kind;
            s1_uuid_reg       <= msg.data.source_uuid;
            s1_seq_reg        <= msg.data.sequence_number;
            s1_local_sec_reg  <= msg.data.local_sec;
            s1_local_nsec_reg <= msg.data.local_nsec;
            s1_fwd_sec_reg    <= {1'b0, msg.data.local_sec} - {1'b0, msg.data.stamp_sec};
            s1_fwd_nsec_reg   <= {1'b0, msg.data.local_nsec} - {1'b0, msg.data.stamp_nsec};
            s1_back_sec_reg   <= {1'b0, msg.data.stamp_sec} - {1'b0, msg.data.request_sent_sec};
            s1_back_nsec_reg  <= {1'b0, msg.data.stamp_nsec}
                                 - {1'b0, msg.data.request_sent_nsec};
        end
    end

    // corrected time: arrival minus truncated half of (forward - backward)
    always_comb
    begin
        diff_sec     = {fwd_sec_reg[32], fwd_sec_reg} - {s1_back_sec_reg[32], s1_back_sec_reg};
        diff_sec_adj = diff_sec + {33'd0, diff_sec[33]};
        half_sec     = diff_sec_adj[33:1];
        base_sec     = s1_local_sec_reg - half_sec[31:0];

        diff_nsec     = {fwd_nsec_reg[30], fwd_nsec_reg}
                        - {s1_back_nsec_reg[30], s1_back_nsec_reg};
        diff_nsec_adj = diff_nsec + {31'd0, diff_nsec[31]};
        half_nsec     = diff_nsec_adj[31:1];
        raw_nsec      = {3'b000, s1_local_nsec_reg} - {{2{half_nsec[30]}}, half_nsec};

        if (raw_nsec[32])
        begin
            norm_nsec = raw_nsec + NSEC_PER_SEC;
            norm_sec  = base_sec - 32'd1;
        end
        else if (raw_nsec >= NSEC_PER_SEC)
        begin
            norm_nsec = raw_nsec - NSEC_PER_SEC;
            norm_sec  = base_sec + 32'd1;
        end
        else
        begin
            norm_nsec = raw_nsec;
            norm_sec  = base_sec;
        end
    end

    assign seq_expected = {1'b0, held_seq_reg} + 17'd1;

    always_comb
    begin
        mode_next      = mode_reg;
        held_uuid_next = held_uuid_reg;
        held_seq_next  = held_seq_reg;
        fwd_sec_next   = fwd_sec_reg;
        fwd_nsec_next  = fwd_nsec_reg;

        out_data_next.status             = STATUS_OK;
        out_data_next.send_delay_request = 1'b0;
        out_data_next.clock_set          = 1'b0;
        out_data_next.corrected_sec      = 32'd0;
        out_data_next.corrected_nsec     = 30'd0;

        case (s1_kind_reg)
            KIND_BAD_VERSION:
            begin
                out_data_next.status = STATUS_NOT_V1;
            end
            KIND_SYNC:
            begin
                held_seq_next = s1_seq_reg;
                if (mode_reg != MODE_IDLE)
                begin
                    out_data_next.status = STATUS_SYNC_BUSY;
                end
                else
                begin
                    held_uuid_next = s1_uuid_reg;
                    fwd_sec_next   = s1_fwd_sec_reg;
                    fwd_nsec_next  = s1_fwd_nsec_reg;
                    mode_next      = MODE_AWAIT_FUP;
                end
            end
            KIND_FOLLOW_UP:
            begin
                if (s1_uuid_reg != held_uuid_reg || seq_expected != {1'b0, s1_seq_reg})
                begin
                    out_data_next.status = STATUS_FUP_MISMATCH;
                    mode_next            = MODE_IDLE;
                end
                else
                begin
                    out_data_next.send_delay_request = 1'b1;
                    mode_next                        = MODE_AWAIT_DRESP;
                end
            end
            KIND_DELAY_RESP:
            begin
                out_data_next.clock_set      = 1'b1;
                out_data_next.corrected_sec  = norm_sec;
                out_data_next.corrected_nsec = norm_nsec[29:0];
                mode_next                    = MODE_IDLE;
            end
            default:
            begin
                out_data_next.status = STATUS_UNSUPPORTED;
            end
        endcase

        out_data_next.mode_after = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            held_uuid_reg <= 48'd0;
            held_seq_reg  <= 16'd0;
            fwd_sec_reg   <= 33'sd0;
            fwd_nsec_reg  <= 31'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                mode_reg      <= mode_next;
                held_uuid_reg <= held_uuid_next;
                held_seq_reg  <= held_seq_next;
                fwd_sec_reg   <= fwd_sec_next;
                fwd_nsec_reg  <= fwd_nsec_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
